// ===== hdl/pdpc_pkg.sv =====
`default_nettype none

package pdpc_pkg;

  localparam int unsigned QUOT_BITS       = 24;
  localparam int unsigned STEP_BITS       = 5;
  localparam int unsigned TPS_BITS        = 24;
  localparam int unsigned PERIOD_OUT_BITS = 17;
  localparam int unsigned DUTY_BITS       = 17;
  localparam int unsigned FREQ_BITS       = 24;

  localparam logic [STEP_BITS-1:0] DUTY_STEPS = STEP_BITS'(17);
  localparam logic [STEP_BITS-1:0] FREQ_STEPS = STEP_BITS'(24);

  localparam logic CFG_TICKS    = 1'b0;
  localparam logic CFG_LOW_FRAC = 1'b1;

  localparam logic [TPS_BITS-1:0] TPS_RESET      = TPS_BITS'(250000);
  localparam logic                LOW_FRAC_RESET = 1'b1;

  typedef struct packed {
    logic                 start;
    logic [STEP_BITS-1:0] steps;
  } div_req_t;

  typedef enum logic [2:0] {
    PH_RISE  = 3'b001,
    PH_FALL  = 3'b010,
    PH_CLOSE = 3'b100
  } phase_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_DONE = 3'b100
  } ctrl_e;

endpackage

`default_nettype wire

// ===== hdl/pdpc_serial_div.sv =====
`default_nettype none

module pdpc_serial_div #(
  parameter int unsigned PW = 17
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire pdpc_pkg::div_req_t                   req_i,
  input  wire logic [PW-1:0]                        divisor_i,
  input  wire logic [PW-1:0]                        rem_init_i,
  input  wire logic [pdpc_pkg::QUOT_BITS-1:0]       bits_i,
  output logic                                      busy_o,
  output logic      [pdpc_pkg::QUOT_BITS-1:0]       quot_o
);

  logic [pdpc_pkg::STEP_BITS-1:0] cnt_q, cnt_d;
  logic [PW-1:0]                  rem_q, rem_d;
  logic [PW-1:0]                  div_q, div_d;
  logic [pdpc_pkg::QUOT_BITS-1:0] bits_q, bits_d;
  logic [pdpc_pkg::QUOT_BITS-1:0] quot_q, quot_d;
  logic [PW:0]                    shifted;
  logic [PW:0]                    diff;

  assign shifted = {rem_q, bits_q[pdpc_pkg::QUOT_BITS-1]};
  assign diff    = shifted - {1'b0, div_q};

  always_comb begin
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    div_d  = div_q;
    bits_d = bits_q;
    quot_d = quot_q;
    if (req_i.start) begin
      cnt_d  = req_i.steps;
      rem_d  = rem_init_i;
      div_d  = divisor_i;
      bits_d = bits_i;
      quot_d = '0;
    end else if (cnt_q != '0) begin
      cnt_d  = cnt_q - 1'b1;
      bits_d = {bits_q[pdpc_pkg::QUOT_BITS-2:0], 1'b0};
      if (!diff[PW]) begin
        rem_d  = diff[PW-1:0];
        quot_d = {quot_q[pdpc_pkg::QUOT_BITS-2:0], 1'b1};
      end else begin
        rem_d  = shifted[PW-1:0];
        quot_d = {quot_q[pdpc_pkg::QUOT_BITS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    div_q  <= div_d;
    bits_q <= bits_d;
    quot_q <= quot_d;
  end

  assign busy_o = (cnt_q != '0);
  assign quot_o = quot_q;

endmodule

`default_nettype wire

// ===== hdl/pwm_duty_period_capture.sv =====
// PWM duty and period capture.
// Input channel (in_valid_i/in_ready_o) carries one capture stamp per edge
// request: rising, falling, closing rising. Output channel
// (out_valid_o/out_ready_i) returns one result per request with the edge to
// capture next and, on the closing edge, period, duty fraction (Q16, low or
// high time as configured) and frequency in hertz.
// Opening and falling edges: result registered on acceptance.
// Closing edge with nonzero period: two bit-serial restoring dividers run in
// parallel (17 steps for duty, 24 for frequency); the result is registered
// once the 24-step frequency divider is done and the output register is free.
// Zero period: no division is run, and the result is not valid.
// Throughput: one request per cycle on opening and falling edges if the
// receiver keeps up; a closing edge holds off requests until it is answered.
// A result waits in the output register while the receiver stalls; a new
// request is taken only when that register is free or being emptied, and not
// while the dividers run.
// Reset: phase returns to awaiting a rising edge, ticks_per_second to 250000,
// report_low_fraction to 1, no result pending.
// Configuration: cfg_we_i, cfg_index_i, cfg_data_i, written while idle.

`default_nettype none

module pwm_duty_period_capture #(
  parameter int unsigned STAMP_BITS = 16
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   in_valid_i,
  output logic                                        in_ready_o,
  input  wire logic [STAMP_BITS-1:0]                  capture_stamp_i,
  output logic                                        out_valid_o,
  input  wire logic                                   out_ready_i,
  output logic                                        next_edge_rising_o,
  output logic                                        measurement_valid_o,
  output logic      [pdpc_pkg::PERIOD_OUT_BITS-1:0]   period_ticks_o,
  output logic      [pdpc_pkg::DUTY_BITS-1:0]         duty_fraction_o,
  output logic      [pdpc_pkg::FREQ_BITS-1:0]         frequency_hz_o,
  input  wire logic                                   cfg_we_i,
  input  wire logic                                   cfg_index_i,
  input  wire logic [pdpc_pkg::TPS_BITS-1:0]          cfg_data_i
);

  localparam int unsigned PW = STAMP_BITS + 1;

  pdpc_pkg::ctrl_e  st_q, st_d;
  pdpc_pkg::phase_e phase_q, phase_d;

  logic [pdpc_pkg::TPS_BITS-1:0] tps_q, tps_d;
  logic                          low_frac_q, low_frac_d;

  logic [STAMP_BITS-1:0] start_q, start_d;
  logic [STAMP_BITS-1:0] end_q, end_d;
  logic [PW-1:0]         period_q, period_d;
  logic                  meas_q, meas_d;

  logic                                 out_valid_q, out_valid_d;
  logic                                 out_next_q, out_next_d;
  logic                                 out_meas_q, out_meas_d;
  logic [pdpc_pkg::PERIOD_OUT_BITS-1:0] out_period_q, out_period_d;
  logic [pdpc_pkg::DUTY_BITS-1:0]       out_duty_q, out_duty_d;
  logic [pdpc_pkg::FREQ_BITS-1:0]       out_freq_q, out_freq_d;

  logic [STAMP_BITS-1:0] high_w, low_w, sel_w;
  logic [PW-1:0]         period_w;
  logic [PW+pdpc_pkg::PERIOD_OUT_BITS-1:0] period_ext;
  logic                  in_acc, out_free;

  pdpc_pkg::div_req_t              duty_req, freq_req;
  logic                            duty_busy, freq_busy;
  logic [pdpc_pkg::QUOT_BITS-1:0]  duty_quot, freq_quot;

  assign high_w     = end_q - start_q;
  assign low_w      = capture_stamp_i - end_q;
  assign period_w   = {1'b0, high_w} + {1'b0, low_w};
  assign sel_w      = low_frac_q ? low_w : high_w;
  assign period_ext = {{pdpc_pkg::PERIOD_OUT_BITS{1'b0}}, period_q};

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (st_q == pdpc_pkg::ST_IDLE) && out_free;
  assign in_acc     = in_valid_i && in_ready_o;

  pdpc_serial_div #(.PW(PW)) u_duty_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (duty_req),
    .divisor_i  (period_w),
    .rem_init_i ({2'b00, sel_w[STAMP_BITS-1:1]}),
    .bits_i     ({sel_w[0], {(pdpc_pkg::QUOT_BITS-1){1'b0}}}),
    .busy_o     (duty_busy),
    .quot_o     (duty_quot)
  );

  pdpc_serial_div #(.PW(PW)) u_freq_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (freq_req),
    .divisor_i  (period_w),
    .rem_init_i ('0),
    .bits_i     (tps_q),
    .busy_o     (freq_busy),
    .quot_o     (freq_quot)
  );

  always_comb begin
    tps_d      = tps_q;
    low_frac_d = low_frac_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        pdpc_pkg::CFG_TICKS:    tps_d      = cfg_data_i;
        pdpc_pkg::CFG_LOW_FRAC: low_frac_d = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    st_d         = st_q;
    phase_d      = phase_q;
    start_d      = start_q;
    end_d        = end_q;
    period_d     = period_q;
    meas_d       = meas_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_next_d   = out_next_q;
    out_meas_d   = out_meas_q;
    out_period_d = out_period_q;
    out_duty_d   = out_duty_q;
    out_freq_d   = out_freq_q;
    duty_req     = '{start: 1'b0, steps: pdpc_pkg::DUTY_STEPS};
    freq_req     = '{start: 1'b0, steps: pdpc_pkg::FREQ_STEPS};
    unique case (st_q)
      pdpc_pkg::ST_IDLE: begin
        if (in_acc) begin
          unique case (phase_q)
            pdpc_pkg::PH_FALL: begin
              end_d        = capture_stamp_i;
              phase_d      = pdpc_pkg::PH_CLOSE;
              out_valid_d  = 1'b1;
              out_next_d   = 1'b1;
              out_meas_d   = 1'b0;
              out_period_d = '0;
              out_duty_d   = '0;
              out_freq_d   = '0;
            end
            pdpc_pkg::PH_CLOSE: begin
              phase_d  = pdpc_pkg::PH_RISE;
              period_d = period_w;
              meas_d   = (period_w != '0);
              if (period_w != '0) begin
                duty_req.start = 1'b1;
                freq_req.start = 1'b1;
                st_d           = pdpc_pkg::ST_DIV;
              end else begin
                st_d = pdpc_pkg::ST_DONE;
              end
            end
            default: begin
              start_d      = capture_stamp_i;
              phase_d      = pdpc_pkg::PH_FALL;
              out_valid_d  = 1'b1;
              out_next_d   = 1'b0;
              out_meas_d   = 1'b0;
              out_period_d = '0;
              out_duty_d   = '0;
              out_freq_d   = '0;
            end
          endcase
        end
      end
      pdpc_pkg::ST_DIV: begin
        if (!duty_busy && !freq_busy) begin
          st_d = pdpc_pkg::ST_DONE;
        end
      end
      pdpc_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_next_d   = 1'b1;
          out_meas_d   = meas_q;
          out_period_d = meas_q ? period_ext[pdpc_pkg::PERIOD_OUT_BITS-1:0] : '0;
          out_duty_d   = meas_q ? duty_quot[pdpc_pkg::DUTY_BITS-1:0] : '0;
          out_freq_d   = meas_q ? freq_quot[pdpc_pkg::FREQ_BITS-1:0] : '0;
          st_d         = pdpc_pkg::ST_IDLE;
        end
      end
      default: st_d = pdpc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= pdpc_pkg::ST_IDLE;
      phase_q     <= pdpc_pkg::PH_RISE;
      tps_q       <= pdpc_pkg::TPS_RESET;
      low_frac_q  <= pdpc_pkg::LOW_FRAC_RESET;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      phase_q     <= phase_d;
      tps_q       <= tps_d;
      low_frac_q  <= low_frac_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    start_q      <= start_d;
    end_q        <= end_d;
    period_q     <= period_d;
    meas_q       <= meas_d;
    out_next_q   <= out_next_d;
    out_meas_q   <= out_meas_d;
    out_period_q <= out_period_d;
    out_duty_q   <= out_duty_d;
    out_freq_q   <= out_freq_d;
  end

  assign out_valid_o         = out_valid_q;
  assign next_edge_rising_o  = out_next_q;
  assign measurement_valid_o = out_meas_q;
  assign period_ticks_o      = out_period_q;
  assign duty_fraction_o     = out_duty_q;
  assign frequency_hz_o      = out_freq_q;

  a_div_only_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (duty_busy || freq_busy) |-> (st_q == pdpc_pkg::ST_DIV))
    else $error("divider busy outside divide state");

  a_phase_after_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != pdpc_pkg::ST_IDLE) |-> (phase_q == pdpc_pkg::PH_RISE))
    else $error("phase not rearmed after closing edge");

  a_open_not_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !next_edge_rising_o) |-> !measurement_valid_o)
    else $error("measurement reported on opening edge");

  a_accept_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> out_valid_o || (st_q != pdpc_pkg::ST_IDLE))
    else $error("accepted request left no result or work pending");

endmodule

`default_nettype wire
